### rtl/core/ppi_pkg.sv
// Shared types, operation codes and a saturation helper for the particle pool.
// Used by ppi_alu and particle_pool_integrator; depends on nothing.
package ppi_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDOUT,
    S_CHECK,
    S_READ,
    S_LOAD,
    S_MUL,
    S_ADD,
    S_WB
  } state_t;

  // One pool slot as stored in the RAM.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic [31:0]        color;
    logic signed [31:0] life;
  } particle_t;

  localparam int SUM_W = 54;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'(32'sh7fffffff));
    lo = SUM_W'(signed'(32'sh80000000));
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

### rtl/core/ppi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppi_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/ppi_alu.sv
// Shared multiply-by-dt and saturating add unit used for every update step.
// Depends on ppi_pkg.
module ppi_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               load,
  input  logic signed [31:0] operand,
  input  logic [19:0]        dt,
  input  logic signed [31:0] addend,
  output logic signed [31:0] result
);
  import ppi_pkg::*;

  logic signed [52:0] prod;
  logic signed [52:0] scaled;

  // The product is registered; the shift and add follow in the next cycle.
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= 53'(operand) * 53'($signed({1'b0, dt}));
    end
  end

  // Arithmetic shift gives rounding toward minus infinity.
  assign scaled = prod >>> FRAC_BITS;
  assign result = sat32(SUM_W'(scaled) + SUM_W'(addend));

endmodule

### rtl/core/particle_pool_integrator.sv
// Top level of the particle pool: command sequencer, pool RAM and shared ALU.
// Add and no-op finish from idle, a read via S_RDOUT. A tick walks the live slots
// through S_CHECK, S_READ and S_LOAD; a surviving slot then takes S_MUL and S_ADD
// for each of four updates and S_WB, as the single RAM port and the one multiplier
// serve all four updates in turn. Synchronous reset empties the pool; no clearing
// pass. The result strobe lasts one cycle and cannot be stalled.
module particle_pool_integrator #(
  parameter int MAX_PARTICLES = 1024,
  parameter int FRAC_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] acc_x,
  input  logic signed [31:0] acc_y,
  input  logic [31:0]        color_rgba,
  input  logic [30:0]        life_init,
  input  logic [19:0]        dt,
  input  logic [9:0]         read_index,
  output logic               done,
  output logic               accepted,
  output logic [10:0]        live_count,
  output logic               entry_valid,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic [31:0]        out_color,
  output logic signed [31:0] out_life
);
  import ppi_pkg::*;

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int IW = (CW > 10) ? CW : 11;

  state_t             state, state_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [AW-1:0]      rd_addr;
  logic [19:0]        dt_r;
  logic [1:0]         step;
  logic               rd_ok;
  particle_t          work;
  particle_t          loaded;
  particle_t          new_part;
  particle_t          rdata;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  particle_t          ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic               has_room;
  logic               in_range;
  logic signed [31:0] life_new;
  logic               dead;
  logic signed [31:0] alu_op;
  logic signed [31:0] alu_add;
  logic signed [31:0] alu_res;
  logic               alu_load;
  logic               done_next;

  assign busy       = (state != S_IDLE);
  assign live_count = 11'(count);
  assign has_room   = (count < CW'(MAX_PARTICLES));
  assign in_range   = (IW'(read_index) < IW'(count));

  assign new_part = '{pos_x: pos_x, pos_y: pos_y, vel_x: vel_x, vel_y: vel_y,
                      acc_x: acc_x, acc_y: acc_y, color: color_rgba,
                      life: $signed({1'b0, life_init})};

  assign life_new = sat32(SUM_W'(rdata.life) - SUM_W'($signed({1'b0, dt_r})));
  assign dead     = (life_new <= 0);

  always_comb begin
    loaded      = rdata;
    loaded.life = life_new;
  end

  ppi_ram #(
    .WIDTH($bits(particle_t)),
    .DEPTH(MAX_PARTICLES),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  always_comb begin
    unique case (step)
      2'd0: begin
        alu_op  = work.vel_x;
        alu_add = work.pos_x;
      end
      2'd1: begin
        alu_op  = work.vel_y;
        alu_add = work.pos_y;
      end
      2'd2: begin
        alu_op  = work.acc_x;
        alu_add = work.vel_x;
      end
      default: begin
        alu_op  = work.acc_y;
        alu_add = work.vel_y;
      end
    endcase
  end

  ppi_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk    (clk),
    .load   (alu_load),
    .operand(alu_op),
    .dt     (dt_r),
    .addend (alu_add),
    .result (alu_res)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (func == FUNC_TICK) begin
            state_next = S_CHECK;
          end else if (func == FUNC_READ) begin
            state_next = S_RDOUT;
          end
        end
      end
      S_RDOUT: state_next = S_IDLE;
      S_CHECK: state_next = (idx < count) ? S_READ : S_IDLE;
      S_READ:  state_next = S_LOAD;
      S_LOAD:  state_next = dead ? S_CHECK : S_MUL;
      S_MUL:   state_next = S_ADD;
      S_ADD:   state_next = (step == 2'd3) ? S_WB : S_MUL;
      S_WB:    state_next = S_CHECK;
      default: state_next = S_IDLE;
    endcase
  end

  // The result strobe follows add and no-op at once, a read after its RAM access,
  // and a tick once the walk has passed the last live slot.
  assign done_next = ((state == S_IDLE) && start &&
                      ((func == FUNC_ADD) || (func == FUNC_NOP))) ||
                     (state == S_RDOUT) ||
                     ((state == S_CHECK) && !(idx < count));

  // RAM and ALU control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = new_part;
    ram_raddr = rd_addr;
    alu_load  = (state == S_MUL);
    unique case (state)
      S_IDLE: begin
        ram_raddr = AW'(read_index);
        ram_we    = start && (func == FUNC_ADD) && has_room;
      end
      S_WB: begin
        ram_we    = 1'b1;
        ram_waddr = idx[AW-1:0];
        ram_wdata = work;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            accepted    <= (func == FUNC_ADD) && has_room;
            entry_valid <= 1'b0;
            out_pos_x   <= '0;
            out_pos_y   <= '0;
            out_vel_x   <= '0;
            out_vel_y   <= '0;
            out_color   <= '0;
            out_life    <= '0;
            rd_ok       <= in_range;
            idx         <= '0;
            rd_addr     <= '0;
            dt_r        <= dt;
            if ((func == FUNC_ADD) && has_room) begin
              count <= count + 1'b1;
            end
          end
        end
        S_RDOUT: begin
          entry_valid <= rd_ok;
          if (rd_ok) begin
            out_pos_x <= rdata.pos_x;
            out_pos_y <= rdata.pos_y;
            out_vel_x <= rdata.vel_x;
            out_vel_y <= rdata.vel_y;
            out_color <= rdata.color;
            out_life  <= rdata.life;
          end
        end
        S_LOAD: begin
          work <= loaded;
          step <= 2'd0;
          // A dying slot takes the last live particle, which is handled next.
          if (dead) begin
            count   <= count - 1'b1;
            rd_addr <= AW'(count - 1'b1);
          end
        end
        S_ADD: begin
          step <= step + 2'd1;
          unique case (step)
            2'd0:    work.pos_x <= alu_res;
            2'd1:    work.pos_y <= alu_res;
            2'd2:    work.vel_x <= alu_res;
            default: work.vel_y <= alu_res;
          endcase
        end
        S_WB: begin
          idx     <= idx + 1'b1;
          rd_addr <= AW'(idx + 1'b1);
        end
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_PARTICLES))
    else $error("live count above pool size");

  a_wb_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) |-> (idx < count))
    else $error("write-back to a slot that is not live");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(entry_valid && accepted))
    else $error("add and read flags in one result");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDOUT) |=> (done && (state == S_IDLE)))
    else $error("read did not complete");

endmodule

### verif/particle_pool_integrator_tb.sv
// Self-checking testbench for particle_pool_integrator: directed table, pool-full fill,
// then random add/tick/read traffic checked against an in-bench pool predictor.
// Depends on ppi_pkg and the particle_pool_integrator RTL.
`timescale 1ns / 1ps

module particle_pool_integrator_tb;
  import ppi_pkg::*;

  localparam int POOL_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    func_t              op;
    logic signed [31:0] px, py, vx, vy, ax, ay;
    logic [31:0]        col;
    logic [30:0]        life;
    logic [19:0]        step;
    logic [9:0]         idx;
  } command_t;

  typedef struct {
    logic               acc;
    logic [10:0]        cnt;
    logic               ev;
    logic signed [31:0] px, py, vx, vy;
    logic [31:0]        col;
    logic signed [31:0] life;
  } outcome_t;

  logic clk, rst, start, busy, done;
  logic [1:0] func;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
  logic [31:0] color_rgba;
  logic [30:0] life_init;
  logic [19:0] dt;
  logic [9:0] read_index;
  logic accepted, entry_valid;
  logic [10:0] live_count;
  logic signed [31:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_life;
  logic [31:0] out_color;

  particle_pool_integrator u_top (.*);

  particle_t   pool_m[POOL_DEPTH];
  int unsigned live_m;
  outcome_t    pending_q[$];
  int          errors;
  int          cycles;
  int          idle_pct;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic signed [31:0] clip32(logic signed [63:0] v);
    if (v > 64'sh7fffffff) return 32'sh7fffffff;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Product rounded toward minus infinity, as an arithmetic shift.
  function automatic logic signed [63:0] scale_by_dt(logic signed [31:0] a, logic [19:0] d);
    logic signed [63:0] aw;
    logic signed [63:0] dw;
    aw = a;
    dw = {44'd0, d};
    return (aw * dw) >>> 16;
  endfunction

  function automatic void advance_pool(logic [19:0] d);
    int unsigned i;
    logic signed [31:0] v;
    i = 0;
    while (i < live_m) begin
      pool_m[i].life = clip32(64'(pool_m[i].life) - 64'(d));
      if (pool_m[i].life <= 0) begin
        pool_m[i] = pool_m[live_m-1];
        live_m--;
      end else begin
        v = pool_m[i].vel_x;
        pool_m[i].pos_x = clip32(64'(pool_m[i].pos_x) + scale_by_dt(v, d));
        pool_m[i].vel_x = clip32(64'(v) + scale_by_dt(pool_m[i].acc_x, d));
        v = pool_m[i].vel_y;
        pool_m[i].pos_y = clip32(64'(pool_m[i].pos_y) + scale_by_dt(v, d));
        pool_m[i].vel_y = clip32(64'(v) + scale_by_dt(pool_m[i].acc_y, d));
        i++;
      end
    end
  endfunction

  function automatic outcome_t plain_outcome(logic a, int unsigned n);
    outcome_t r;
    r = '{default: '0};
    r.acc = a;
    r.cnt = 11'(n);
    return r;
  endfunction

  function automatic outcome_t apply_command(command_t c);
    outcome_t r;
    r = '{default: '0};
    case (c.op)
      FUNC_ADD: begin
        if (live_m < POOL_DEPTH) begin
          pool_m[live_m] = '{c.px, c.py, c.vx, c.vy, c.ax, c.ay, c.col, {1'b0, c.life}};
          live_m++;
          r.acc = 1'b1;
        end
      end
      FUNC_TICK: advance_pool(c.step);
      FUNC_READ: begin
        if (c.idx < live_m) begin
          r.ev = 1'b1;
          r.px = pool_m[c.idx].pos_x;
          r.py = pool_m[c.idx].pos_y;
          r.vx = pool_m[c.idx].vel_x;
          r.vy = pool_m[c.idx].vel_y;
          r.col = pool_m[c.idx].color;
          r.life = pool_m[c.idx].life;
        end
      end
      default: ;
    endcase
    r.cnt = 11'(live_m);
    return r;
  endfunction

  always @(negedge clk) begin
    outcome_t e;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        report("unexpected transfer", 32'(live_count), 32'd0);
      end else begin
        e = pending_q.pop_front();
        if (accepted !== e.acc) report("accepted", 32'(accepted), 32'(e.acc));
        if (live_count !== e.cnt) report("live_count", 32'(live_count), 32'(e.cnt));
        if (entry_valid !== e.ev) report("entry_valid", 32'(entry_valid), 32'(e.ev));
        if (out_pos_x !== e.px) report("out_pos_x", out_pos_x, e.px);
        if (out_pos_y !== e.py) report("out_pos_y", out_pos_y, e.py);
        if (out_vel_x !== e.vx) report("out_vel_x", out_vel_x, e.vx);
        if (out_vel_y !== e.vy) report("out_vel_y", out_vel_y, e.vy);
        if (out_color !== e.col) report("out_color", out_color, e.col);
        if (out_life !== e.life) report("out_life", out_life, e.life);
      end
    end
  end

  // Called at a rising edge; returns at the edge where the command was taken, or later after a random idle gap.
  task automatic send(command_t c, bit fixed, outcome_t want);
    outcome_t got;
    func <= c.op;
    pos_x <= c.px; pos_y <= c.py; vel_x <= c.vx; vel_y <= c.vy;
    acc_x <= c.ax; acc_y <= c.ay; color_rgba <= c.col; life_init <= c.life;
    dt <= c.step; read_index <= c.idx;
    start <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
    got = apply_command(c);
    pending_q.push_back(fixed ? want : got);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0 || busy);
  endtask

  function automatic command_t mk(func_t op, logic signed [31:0] p, logic signed [31:0] v,
                                  logic signed [31:0] a, logic [31:0] col,
                                  logic [30:0] life, logic [19:0] d, logic [9:0] idx);
    command_t c;
    c = '{op, p, -p, v, ~v, a, ~a, col, life, d, idx};
    return c;
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'($signed($urandom_range(0, 4096)) - 2048) <<< 12;
      default: return $urandom;
    endcase
  endfunction

  function automatic command_t rand_command();
    command_t c;
    int unsigned r;
    int unsigned add_pct;
    c = '{op: FUNC_NOP, px: rand_word(), py: rand_word(), vx: rand_word(), vy: rand_word(),
          ax: rand_word(), ay: rand_word(), col: $urandom, default: '0};
    case ($urandom_range(4))
      0: c.life = '0;
      1: c.life = 31'h7fffffff;
      2: c.life = 31'($urandom);
      default: c.life = 31'($urandom_range(1, 32'h80000));
    endcase
    case ($urandom_range(3))
      0: c.step = 20'hfffff;
      1: c.step = 20'($urandom);
      default: c.step = 20'($urandom_range(0, 20'h4000));
    endcase
    c.idx = ($urandom_range(4) == 0 || live_m == 0) ? 10'($urandom) :
            10'($urandom_range(0, live_m - 1));
    add_pct = (live_m < 8) ? 60 : (live_m > 48) ? 10 : 35;
    r = $urandom_range(99);
    if (r < add_pct) c.op = FUNC_ADD;
    else if (r < add_pct + 22) c.op = FUNC_TICK;
    else if (r < 96) c.op = FUNC_READ;
    else c.op = FUNC_NOP;
    return c;
  endfunction

  typedef struct {
    command_t cmd;
    bit       fixed;
    outcome_t want;
  } row_t;

  initial begin
    row_t rows[$];
    command_t c;
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_NOP;
    {pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, color_rgba} = '0;
    life_init = '0; dt = '0; read_index = '0;
    errors = 0; cycles = 0; live_m = 0; idle_pct = 23;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back('{mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 1, plain_outcome(0, 0)});
    rows.push_back('{mk(FUNC_NOP, 0, 0, 0, 0, 0, 0, 0), 1, plain_outcome(0, 0)});
    rows.push_back('{mk(FUNC_TICK, 0, 0, 0, 0, 0, 20'hfffff, 0), 1, plain_outcome(0, 0)});
    rows.push_back('{mk(FUNC_ADD, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                        32'hffffffff, 31'h7fffffff, 0, 0), 1, plain_outcome(1, 1)});
    rows.push_back('{mk(FUNC_ADD, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'h0, 31'h40000, 0, 0), 1, plain_outcome(1, 2)});
    rows.push_back('{mk(FUNC_ADD, 32'sh10000, -32'sh18000, 32'sh3, 32'h12345678,
                        31'h0, 0, 0), 1, plain_outcome(1, 3)});
    rows.push_back('{mk(FUNC_ADD, -32'sh1, -32'sh1, -32'sh1, 32'ha5a5a5a5,
                        31'h200000, 0, 0), 1, plain_outcome(1, 4)});
    rows.push_back('{mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 0, plain_outcome(0, 0)});
    rows.push_back('{mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 1), 0, plain_outcome(0, 0)});
    rows.push_back('{mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 3), 0, plain_outcome(0, 0)});
    rows.push_back('{mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 10'h3ff), 1, plain_outcome(0, 4)});
    rows.push_back('{mk(FUNC_TICK, 0, 0, 0, 0, 0, 20'h0, 0), 0, plain_outcome(0, 0)});
    rows.push_back('{mk(FUNC_TICK, 0, 0, 0, 0, 0, 20'h1, 0), 0, plain_outcome(0, 0)});
    rows.push_back('{mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 0, plain_outcome(0, 0)});
    rows.push_back('{mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 2), 0, plain_outcome(0, 0)});
    rows.push_back('{mk(FUNC_TICK, 0, 0, 0, 0, 0, 20'hfffff, 0), 0, plain_outcome(0, 0)});
    rows.push_back('{mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 0, plain_outcome(0, 0)});
    rows.push_back('{mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 1), 0, plain_outcome(0, 0)});
    rows.push_back('{mk(FUNC_TICK, 0, 0, 0, 0, 0, 20'hfffff, 0), 0, plain_outcome(0, 0)});
    rows.push_back('{mk(FUNC_TICK, 0, 0, 0, 0, 0, 20'hfffff, 0), 0, plain_outcome(0, 0)});
    foreach (rows[i]) send(rows[i].cmd, rows[i].fixed, rows[i].want);
    drain();

    // Fill the pool, then one add past full; lives are short so max-dt ticks empty it.
    idle_pct = 0;
    while (live_m < POOL_DEPTH) begin
      c = rand_command();
      c.op = FUNC_ADD;
      c.life = 31'($urandom_range(1, 32'h1fffff));
      send(c, 0, plain_outcome(0, 0));
    end
    c.life = 31'h7fffffff;
    send(c, 1, plain_outcome(0, POOL_DEPTH));
    send(mk(FUNC_TICK, 0, 0, 0, 0, 0, 20'h100, 0), 0, plain_outcome(0, 0));
    send(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 10'h3ff), 0, plain_outcome(0, 0));
    while (live_m != 0) send(mk(FUNC_TICK, 0, 0, 0, 0, 0, 20'hfffff, 0), 0,
                             plain_outcome(0, 0));
    drain();

    for (int n = 0; n < 580; n++) begin
      if (n == 193 || n == 386) drain();
      idle_pct = (n < 193) ? 23 : (n < 386) ? 56 : 0;
      send(rand_command(), 0, plain_outcome(0, 0));
    end
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/ppi_pkg.sv
rtl/core/ppi_ram.sv
rtl/core/ppi_alu.sv
rtl/core/particle_pool_integrator.sv
verif/particle_pool_integrator_tb.sv
